FILE: hdl/r40wl_pkg.sv
package r40wl_pkg;

    localparam int MAX_WORDS_DEF  = 20;
    localparam int CHARS_PER_WORD = 6;
    // characters actually packed per word: two halves of three
    localparam int PACK_LIMIT     = (CHARS_PER_WORD < 6) ? CHARS_PER_WORD : 6;

    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 6;
    localparam int HALF_W   = 16;
    localparam int INDEX_W  = 5;
    localparam int CCOUNT_W = 3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd64;  // 'A' - 1
    localparam logic [CHAR_W-1:0] DIGIT_BIAS  = 8'd18;  // '1' - 31
    localparam logic [CODE_W-1:0] DASH_CODE   = 6'd27;  // '-' code

    localparam logic [HALF_W-1:0] WEIGHT_HI  = 16'd1600;
    localparam logic [HALF_W-1:0] WEIGHT_MID = 16'd40;
    localparam logic [HALF_W-1:0] WEIGHT_LO  = 16'd1;

    typedef enum logic [2:0] {
        ST_WORD    = 3'd0,
        ST_FINAL   = 3'd1,
        ST_END     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADCHAR = 3'd4,
        ST_TOOMANY = 3'd5
    } t_status;

    typedef struct packed {
        logic [CCOUNT_W-1:0] chars;
        logic [HALF_W-1:0]   first_half;
        logic [HALF_W-1:0]   second_half;
        logic                discarding;
        logic                after_term;
    } t_lex_state;

    typedef struct packed {
        t_status             status;
        logic [HALF_W-1:0]   first_half;
        logic [HALF_W-1:0]   second_half;
        logic [INDEX_W-1:0]  word_index;
        logic                done;
    } t_lex_result;

    // character code 1..39, or 0 for an illegal byte
    function automatic logic [CODE_W-1:0] classify(input logic [CHAR_W-1:0] c_in);
        logic [CHAR_W-1:0] c;
        logic [CODE_W-1:0] code;
        c    = c_in;
        code = '0;
        if (c inside {["a":"z"]}) begin
            c = c - CASE_GAP;
        end
        if (c inside {["A":"Z"]}) begin
            code = CODE_W'(c - LETTER_BIAS);
        end else if (c inside {["1":"9"]}) begin
            code = CODE_W'(c - DIGIT_BIAS);
        end else if (c == CH_DASH) begin
            code = DASH_CODE;
        end
        return code;
    endfunction

endpackage

FILE: hdl/radix40_word_lexer_core.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------------------
// input    | in        | i_in_valid / o_in_ready   | i_char_code
// result   | out       | o_out_valid / i_out_ready | o_status, o_word_first_half,
//          |           |                           | o_word_second_half, o_word_index,
//          |           |                           | o_command_done
//
// One character per cycle while no result stall holds the input. A transfer lands in the input
// register and is lexed from there; its result (if any) then enters the result register.
// Synchronous active-low reset clears both valid flags and the lexer state.
// A result held in the result register stalls only a character that makes a result;
// characters that make none keep flowing underneath it.
module radix40_word_lexer_core #(
    parameter int MAX_WORDS = r40wl_pkg::MAX_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [r40wl_pkg::CHAR_W-1:0]      i_char_code,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic [r40wl_pkg::HALF_W-1:0]      o_word_first_half,
    output logic [r40wl_pkg::HALF_W-1:0]      o_word_second_half,
    output logic [r40wl_pkg::INDEX_W-1:0]     o_word_index,
    output logic                              o_command_done
);

    localparam int WCNT_W = $clog2(MAX_WORDS + 1);

    logic                           r_in_valid;
    logic [r40wl_pkg::CHAR_W-1:0]   r_char;
    r40wl_pkg::t_lex_state          r_state;
    r40wl_pkg::t_lex_state          n_state;
    logic [WCNT_W-1:0]              r_words;
    logic [WCNT_W-1:0]              n_words;
    logic                           r_out_valid;
    r40wl_pkg::t_lex_result         r_res;
    r40wl_pkg::t_lex_result         n_res;
    logic                           res_valid;
    logic                           advance;

    r40wl_step #(
        .MAX_WORDS (MAX_WORDS),
        .WCNT_W    (WCNT_W)
    ) u_step (
        .i_char      (r_char),
        .i_state     (r_state),
        .i_words     (r_words),
        .o_state     (n_state),
        .o_words     (n_words),
        .o_res_valid (res_valid),
        .o_res       (n_res)
    );

    // hold the character only while its result cannot enter the result register
    assign advance    = r_in_valid && (!res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_words     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
                r_words <= n_words;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
        end
        if (advance && res_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_res.status;
    assign o_word_first_half  = r_res.first_half;
    assign o_word_second_half = r_res.second_half;
    assign o_word_index       = r_res.word_index;
    assign o_command_done     = r_res.done;

endmodule

FILE: hdl/r40wl_step.sv
module r40wl_step #(
    parameter int MAX_WORDS = r40wl_pkg::MAX_WORDS_DEF,
    parameter int WCNT_W    = $clog2(MAX_WORDS + 1)
) (
    input  logic [r40wl_pkg::CHAR_W-1:0] i_char,
    input  r40wl_pkg::t_lex_state        i_state,
    input  logic [WCNT_W-1:0]            i_words,
    output r40wl_pkg::t_lex_state        o_state,
    output logic [WCNT_W-1:0]            o_words,
    output logic                         o_res_valid,
    output r40wl_pkg::t_lex_result       o_res
);

    localparam logic [WCNT_W-1:0] WORD_LIMIT = WCNT_W'(MAX_WORDS);

    logic [r40wl_pkg::CODE_W-1:0]   code;
    logic [r40wl_pkg::HALF_W-1:0]   weight;
    logic [r40wl_pkg::HALF_W-1:0]   term;
    logic [WCNT_W+r40wl_pkg::INDEX_W-1:0] words_wide;
    logic                           is_term;
    logic                           full;

    assign code       = r40wl_pkg::classify(i_char);
    assign is_term    = (i_char == r40wl_pkg::CH_NUL) || (i_char == r40wl_pkg::CH_DOT)
                        || (i_char == r40wl_pkg::CH_COMMA);
    assign full       = (i_words >= WORD_LIMIT);
    assign words_wide = {{r40wl_pkg::INDEX_W{1'b0}}, i_words};

    always_comb begin
        case (i_state.chars)
            3'd0, 3'd3: weight = r40wl_pkg::WEIGHT_HI;
            3'd1, 3'd4: weight = r40wl_pkg::WEIGHT_MID;
            default:    weight = r40wl_pkg::WEIGHT_LO;
        endcase
    end

    assign term = r40wl_pkg::HALF_W'({10'd0, code} * weight);

    always_comb begin
        o_state            = i_state;
        o_state.after_term = 1'b0;
        o_words            = i_words;
        o_res_valid        = 1'b0;
        o_res              = '0;
        o_res.status       = r40wl_pkg::ST_WORD;

        if (i_state.discarding) begin
            if (i_char == r40wl_pkg::CH_NUL) begin
                o_state.discarding = 1'b0;
            end
        end else if (is_term) begin
            if (!(i_char == r40wl_pkg::CH_NUL && i_state.after_term)) begin
                o_res_valid         = 1'b1;
                o_res.done          = 1'b1;
                o_state.chars       = '0;
                o_state.first_half  = '0;
                o_state.second_half = '0;
                o_words             = '0;
                if (i_state.chars != '0 && full) begin
                    o_res.status       = r40wl_pkg::ST_TOOMANY;
                    o_state.discarding = (i_char != r40wl_pkg::CH_NUL);
                end else begin
                    if (i_state.chars != '0) begin
                        o_res.status      = r40wl_pkg::ST_FINAL;
                        o_res.first_half  = i_state.first_half;
                        o_res.second_half = i_state.second_half;
                        o_res.word_index  = words_wide[r40wl_pkg::INDEX_W-1:0];
                    end else if (i_words != '0) begin
                        o_res.status     = r40wl_pkg::ST_END;
                        o_res.word_index = words_wide[r40wl_pkg::INDEX_W-1:0];
                    end else begin
                        o_res.status = r40wl_pkg::ST_EMPTY;
                    end
                    o_state.after_term = (i_char != r40wl_pkg::CH_NUL);
                end
            end
        end else if (i_char == r40wl_pkg::CH_SPACE) begin
            if (i_state.chars != '0) begin
                o_res_valid         = 1'b1;
                o_state.chars       = '0;
                o_state.first_half  = '0;
                o_state.second_half = '0;
                if (full) begin
                    o_res.status       = r40wl_pkg::ST_TOOMANY;
                    o_res.done         = 1'b1;
                    o_words            = '0;
                    o_state.discarding = 1'b1;
                end else begin
                    o_res.first_half  = i_state.first_half;
                    o_res.second_half = i_state.second_half;
                    o_res.word_index  = words_wide[r40wl_pkg::INDEX_W-1:0];
                    o_words           = i_words + 1'b1;
                end
            end
        end else if (code == '0) begin
            o_res_valid         = 1'b1;
            o_res.status        = r40wl_pkg::ST_BADCHAR;
            o_res.done          = 1'b1;
            o_state.chars       = '0;
            o_state.first_half  = '0;
            o_state.second_half = '0;
            o_words             = '0;
            o_state.discarding  = 1'b1;
        end else if (i_state.chars < r40wl_pkg::CCOUNT_W'(r40wl_pkg::PACK_LIMIT)) begin
            // pack into the half that this position belongs to
            if (i_state.chars < 3'd3) begin
                o_state.first_half = i_state.first_half + term;
            end else begin
                o_state.second_half = i_state.second_half + term;
            end
            o_state.chars = i_state.chars + 1'b1;
        end
    end

endmodule
